// ===== rtl/core/jdlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdlp_pkg: shared types of the least-pending job dispatcher
// Payload structs, event and action codes, configuration register indexes.
// ----------------------------------------------------------------------------
package jdlp_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WORKERS_IN_USE = 1'b0,
    CFG_PENDING_LIMIT  = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    ACT_PUSH   = 1'b0,
    ACT_FINISH = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    EV_DISPATCHED = 3'd0,
    EV_QUEUED     = 3'd1,
    EV_REFILLED   = 3'd2,
    EV_FREED      = 3'd3,
    EV_REJECTED   = 3'd4
  } event_e;

  typedef struct packed {
    logic [0:0]  action;
    logic [31:0] job_handle;
    logic [31:0] completion_tag;
    logic [7:0]  mailbox_free_mask;
    logic [2:0]  done_worker;
    logic [4:0]  done_slot;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [2:0]  worker;
    logic [4:0]  slot;
    logic [31:0] sent_job;
    logic [31:0] finished_tag;
    logic [5:0]  busy_count;
    logic [4:0]  waiting_count;
  } out_item_t;

endpackage

// ===== rtl/core/jdlp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdlp_in_if / jdlp_out_if: valid-ready channels of the job dispatcher
// One transfer when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface jdlp_in_if;
  import jdlp_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface jdlp_out_if;
  import jdlp_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/job_dispatcher_least_pending_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// job_dispatcher_least_pending_core: least-pending job dispatcher
// Picks the least loaded worker, claims a free slot, queues overflow in a
// bounded wait FIFO and refills or frees slots on completion.
// ----------------------------------------------------------------------------
// Usage:
//   job_i carries commands (push or finish), evt_o one event per command.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write workers_in_use and pending_limit;
//   write them only while the dispatcher is idle.
//   One command at a time: job_i.ready is high only while the sequencer idles.
//   A push walks the active workers one per cycle through a shared compare,
//   then decides, then walks busy slots one per cycle from the rotating
//   search pointer. A push with no eligible worker, or one that finds every
//   slot busy, goes on to the wait FIFO.
//   A finish waits for the registered slot and wait memory reads; a finish
//   on an idle slot skips them.
//   The event register lets the next command enter while an event waits;
//   a stalled evt_o holds the following command in its last step.
//   Reset clears all counts, pointers and slot valid bits and loads
//   workers_in_use = 8, pending_limit = 4. Slot and wait memories are not
//   cleared; valid bits and the FIFO count guard every read.
// ----------------------------------------------------------------------------
module job_dispatcher_least_pending_core #(
  parameter int MAX_WORKERS = 8,
  parameter int MAX_PENDING = 4,
  parameter int WAIT_DEPTH  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [jdlp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [jdlp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  jdlp_in_if.sink                       job_i,
  jdlp_out_if.source                    evt_o
);
  import jdlp_pkg::*;

  localparam int SLOTS = MAX_WORKERS * MAX_PENDING;
  localparam int CW    = $clog2(MAX_WORKERS + 1);
  localparam int XW    = (CW > 4) ? CW : 4;
  localparam int WW    = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int PW    = $clog2(MAX_PENDING + 1);
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DSW   = (SW > 5) ? SW : 5;
  localparam int SCW   = $clog2(SLOTS + 1);
  localparam int BXW   = (SCW > 6) ? SCW : 6;
  localparam int DW    = $clog2(WAIT_DEPTH);
  localparam int TW    = $clog2(WAIT_DEPTH + 1);
  localparam int TXW   = (TW > 5) ? TW : 5;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_WSCAN = 7'b0000010,
    ST_SSCAN = 7'b0000100,
    ST_QUEUE = 7'b0001000,
    ST_FCHK  = 7'b0010000,
    ST_FDONE = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [3:0]        workers_q, workers_d;
  logic [2:0]        limit_q, limit_d;
  logic [PW-1:0]     pend_q [MAX_WORKERS];
  logic [PW-1:0]     pend_d [MAX_WORKERS];
  logic [SLOTS-1:0]  valid_q, valid_d;
  logic [SW-1:0]     start_q, start_d;
  logic [SCW-1:0]    busy_q, busy_d;
  logic [DW-1:0]     tail_q, tail_d;
  logic [DW-1:0]     head_q, head_d;
  logic [TW-1:0]     total_q, total_d;
  logic [XW-1:0]     idx_q, idx_d;
  logic [XW-1:0]     pick_q, pick_d;
  logic              pick_ok_q, pick_ok_d;
  logic [PW-1:0]     minp_q, minp_d;
  logic [SW-1:0]     sidx_q, sidx_d;
  logic [SW-1:0]     scnt_q, scnt_d;
  in_item_t          item_q, item_d;
  out_item_t         res_q, res_d;
  out_item_t         out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic [63:0]       slot_mem [SLOTS];
  logic [63:0]       wait_mem [WAIT_DEPTH];
  logic [63:0]       slot_rdata_q;
  logic [63:0]       wait_rdata_q;
  logic              slot_we;
  logic [SW-1:0]     slot_waddr;
  logic [63:0]       slot_wdata;
  logic              wait_we;

  logic [XW-1:0]     n_w;
  logic [PW-1:0]     lim_w;
  logic [XW-1:0]     dw_ext;
  logic [DSW-1:0]    ds_ext;
  logic [DSW-1:0]    sidx_ext;
  logic [SW-1:0]     ds_idx;
  logic              ds_ok;
  logic              dw_ok;
  logic [WW-1:0]     rd_w;
  logic [PW-1:0]     pend_rd;
  logic              room;
  logic [SW-1:0]     sidx_inc;
  logic [BXW-1:0]    busy_ext;
  logic [TXW-1:0]    total_ext;

  assign n_w       = (int'(workers_q) > MAX_WORKERS) ? XW'(MAX_WORKERS) : XW'(workers_q);
  assign lim_w     = (int'(limit_q) > MAX_PENDING) ? PW'(MAX_PENDING) : PW'(limit_q);
  assign dw_ext    = XW'(item_q.done_worker);
  assign ds_ext    = DSW'(item_q.done_slot);
  assign sidx_ext  = DSW'(sidx_q);
  assign ds_idx    = ds_ext[SW-1:0];
  assign ds_ok     = int'(item_q.done_slot) < SLOTS;
  assign dw_ok     = int'(item_q.done_worker) < MAX_WORKERS;
  assign rd_w      = (state_q == ST_FDONE) ? dw_ext[WW-1:0] : idx_q[WW-1:0];
  assign pend_rd   = pend_q[rd_w];
  assign room      = (idx_q < XW'(8)) && item_q.mailbox_free_mask[idx_q[2:0]];
  assign sidx_inc  = (sidx_q == SW'(SLOTS - 1)) ? '0 : sidx_q + 1'b1;
  assign busy_ext  = BXW'(busy_q);
  assign total_ext = TXW'(total_q);

  assign job_i.ready = (state_q == ST_IDLE);
  assign evt_o.valid = out_valid_q;
  assign evt_o.data  = out_q;

  always_comb begin
    state_d     = state_q;
    workers_d   = workers_q;
    limit_d     = limit_q;
    pend_d      = pend_q;
    valid_d     = valid_q;
    start_d     = start_q;
    busy_d      = busy_q;
    tail_d      = tail_q;
    head_d      = head_q;
    total_d     = total_q;
    idx_d       = idx_q;
    pick_d      = pick_q;
    pick_ok_d   = pick_ok_q;
    minp_d      = minp_q;
    sidx_d      = sidx_q;
    scnt_d      = scnt_q;
    item_d      = item_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    slot_we     = 1'b0;
    slot_waddr  = sidx_q;
    slot_wdata  = {item_q.completion_tag, item_q.job_handle};
    wait_we     = 1'b0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WORKERS_IN_USE: workers_d = cfg_wdata_i;
        CFG_PENDING_LIMIT:  limit_d   = cfg_wdata_i[2:0];
        default: ;
      endcase
    end

    if (out_valid_q && evt_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (job_i.valid) begin
          item_d    = job_i.data;
          idx_d     = '0;
          minp_d    = lim_w;
          pick_ok_d = 1'b0;
          state_d   = (job_i.data.action == ACT_PUSH) ? ST_WSCAN : ST_FCHK;
        end
      end
      ST_WSCAN: begin
        if (idx_q < n_w) begin
          if (room && pend_rd < minp_q) begin
            pick_d    = idx_q;
            minp_d    = pend_rd;
            pick_ok_d = 1'b1;
          end
          idx_d = idx_q + 1'b1;
        end else if (pick_ok_q) begin
          sidx_d  = start_q;
          scnt_d  = '0;
          state_d = ST_SSCAN;
        end else begin
          state_d = ST_QUEUE;
        end
      end
      ST_SSCAN: begin
        if (!valid_q[sidx_q]) begin
          valid_d[sidx_q]          = 1'b1;
          slot_we                  = 1'b1;
          start_d                  = sidx_inc;
          busy_d                   = busy_q + 1'b1;
          pend_d[pick_q[WW-1:0]]   = minp_q + 1'b1;
          res_d                    = '0;
          res_d.event_res          = EV_DISPATCHED;
          res_d.worker             = pick_q[2:0];
          res_d.slot               = sidx_ext[4:0];
          res_d.sent_job           = item_q.job_handle;
          state_d                  = ST_EMIT;
        end else if (scnt_q == SW'(SLOTS - 1)) begin
          state_d = ST_QUEUE;
        end else begin
          sidx_d = sidx_inc;
          scnt_d = scnt_q + 1'b1;
        end
      end
      ST_QUEUE: begin
        res_d = '0;
        if (total_q == TW'(WAIT_DEPTH)) begin
          res_d.event_res = EV_REJECTED;
        end else begin
          wait_we         = 1'b1;
          tail_d          = (tail_q == DW'(WAIT_DEPTH - 1)) ? '0 : tail_q + 1'b1;
          total_d         = total_q + 1'b1;
          res_d.event_res = EV_QUEUED;
        end
        state_d = ST_EMIT;
      end
      ST_FCHK: begin
        if (!ds_ok || !valid_q[ds_idx]) begin
          res_d           = '0;
          res_d.event_res = EV_FREED;
          res_d.worker    = item_q.done_worker;
          res_d.slot      = item_q.done_slot;
          state_d         = ST_EMIT;
        end else begin
          state_d = ST_FDONE;
        end
      end
      ST_FDONE: begin
        res_d              = '0;
        res_d.worker       = item_q.done_worker;
        res_d.slot         = item_q.done_slot;
        res_d.finished_tag = slot_rdata_q[63:32];
        if (total_q != '0) begin
          slot_we         = 1'b1;
          slot_waddr      = ds_idx;
          slot_wdata      = wait_rdata_q;
          total_d         = total_q - 1'b1;
          head_d          = (head_q == DW'(WAIT_DEPTH - 1)) ? '0 : head_q + 1'b1;
          res_d.event_res = EV_REFILLED;
          res_d.sent_job  = wait_rdata_q[31:0];
        end else begin
          if (dw_ok && pend_rd != '0) begin
            pend_d[rd_w] = pend_rd - 1'b1;
          end
          valid_d[ds_idx] = 1'b0;
          if (busy_q != '0) begin
            busy_d = busy_q - 1'b1;
          end
          res_d.event_res = EV_FREED;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || evt_o.ready) begin
          out_valid_d         = 1'b1;
          out_d               = res_q;
          out_d.busy_count    = busy_ext[5:0];
          out_d.waiting_count = total_ext[4:0];
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      workers_q   <= 4'd8;
      limit_q     <= 3'd4;
      for (int i = 0; i < MAX_WORKERS; i++) begin
        pend_q[i] <= '0;
      end
      valid_q     <= '0;
      start_q     <= '0;
      busy_q      <= '0;
      tail_q      <= '0;
      head_q      <= '0;
      total_q     <= '0;
      idx_q       <= '0;
      pick_ok_q   <= 1'b0;
      sidx_q      <= '0;
      scnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      workers_q   <= workers_d;
      limit_q     <= limit_d;
      pend_q      <= pend_d;
      valid_q     <= valid_d;
      start_q     <= start_d;
      busy_q      <= busy_d;
      tail_q      <= tail_d;
      head_q      <= head_d;
      total_q     <= total_d;
      idx_q       <= idx_d;
      pick_ok_q   <= pick_ok_d;
      sidx_q      <= sidx_d;
      scnt_q      <= scnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q <= pick_d;
    minp_q <= minp_d;
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rdata_q <= slot_mem[ds_idx];
  end

  always_ff @(posedge clk_i) begin
    if (wait_we) begin
      wait_mem[tail_q] <= {item_q.completion_tag, item_q.job_handle};
    end
    wait_rdata_q <= wait_mem[head_q];
  end

  a_busy_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(busy_q))
    else $error("busy count differs from occupied slots");

  a_wait_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(total_q) <= WAIT_DEPTH)
    else $error("wait FIFO count above depth");

  a_wait_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(head_q) + int'(total_q) == int'(tail_q)) ||
    (int'(head_q) + int'(total_q) == int'(tail_q) + WAIT_DEPTH))
    else $error("wait FIFO head, tail and count disagree");

  a_pick_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SSCAN) |-> (pick_ok_q && minp_q < lim_w))
    else $error("slot search without an eligible worker");

  a_emit_drives_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && (!out_valid_q || evt_o.ready)) |=> out_valid_q)
    else $error("event not presented after emit");

endmodule

// ===== tb/dispatch_event_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dispatch_event_check: event predictor and comparator for the dispatcher
// Tracks the configuration writes and every command transfer, works out the
// event that each command must cause from its own copy of the worker loads,
// busy slots and wait FIFO, and compares each event transfer field by field
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module dispatch_event_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [jdlp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [jdlp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  jdlp_in_if                              job_mon,
  jdlp_out_if                             evt_mon,
  output int                              mismatches_o,
  output int                              outstanding_o,
  output logic [31:0]                     slot_busy_o,
  output logic [31:0][2:0]                slot_owner_o
);
  import jdlp_pkg::*;

  localparam int WORKERS     = 8;
  localparam int PENDING_MAX = 4;
  localparam int SLOT_COUNT  = WORKERS * PENDING_MAX;
  localparam int WAIT_SLOTS  = 16;

  logic [3:0]       workers_cfg;
  logic [2:0]       limit_cfg;
  logic [2:0]       pending_cnt [WORKERS];
  logic [31:0]      slot_busy;
  logic [31:0][2:0] slot_owner;
  logic [31:0]      slot_job [SLOT_COUNT];
  logic [31:0]      slot_tag [SLOT_COUNT];
  logic [4:0]       search_ptr;
  logic [5:0]       busy_total;
  logic [31:0]      wait_job [WAIT_SLOTS];
  logic [31:0]      wait_tag [WAIT_SLOTS];
  logic [3:0]       wait_wr;
  logic [4:0]       wait_cnt;
  out_item_t        event_queue [$];
  int               evt_seen;

  assign slot_busy_o  = slot_busy;
  assign slot_owner_o = slot_owner;

  function automatic out_item_t dispatch_step(input in_item_t cmd);
    out_item_t   ev;
    int          n;
    int          lim;
    int          lowest;
    int          pick;
    int          found;
    logic [4:0]  idx;
    logic [3:0]  head;
    logic [4:0]  ds;
    logic [2:0]  dw;
    ev = '0;
    ds = cmd.done_slot;
    dw = cmd.done_worker;
    if (cmd.action == ACT_PUSH) begin
      n = (int'(workers_cfg) > WORKERS) ? WORKERS : int'(workers_cfg);
      lim = (int'(limit_cfg) > PENDING_MAX) ? PENDING_MAX : int'(limit_cfg);
      lowest = lim;
      pick = -1;
      for (int u = 0; u < n; u++) begin
        if (cmd.mailbox_free_mask[u] && int'(pending_cnt[u]) < lowest) begin
          pick = u;
          lowest = int'(pending_cnt[u]);
        end
      end
      found = -1;
      if (pick >= 0) begin
        idx = search_ptr;
        for (int k = 0; k < SLOT_COUNT; k++) begin
          if (!slot_busy[idx]) begin
            found = int'(idx);
            break;
          end
          idx = idx + 5'd1;
        end
      end
      if (found >= 0) begin
        pending_cnt[pick] = pending_cnt[pick] + 3'd1;
        slot_busy[found] = 1'b1;
        slot_owner[found] = pick[2:0];
        slot_job[found] = cmd.job_handle;
        slot_tag[found] = cmd.completion_tag;
        search_ptr = found[4:0] + 5'd1;
        busy_total = busy_total + 6'd1;
        ev.event_res = EV_DISPATCHED;
        ev.worker = pick[2:0];
        ev.slot = found[4:0];
        ev.sent_job = cmd.job_handle;
      end else if (int'(wait_cnt) >= WAIT_SLOTS) begin
        ev.event_res = EV_REJECTED;
      end else begin
        wait_job[wait_wr] = cmd.job_handle;
        wait_tag[wait_wr] = cmd.completion_tag;
        wait_wr = wait_wr + 4'd1;
        wait_cnt = wait_cnt + 5'd1;
        ev.event_res = EV_QUEUED;
      end
    end else begin
      ev.event_res = EV_FREED;
      ev.worker = dw;
      ev.slot = ds;
      if (slot_busy[ds]) begin
        ev.finished_tag = slot_tag[ds];
        if (wait_cnt != '0) begin
          head = wait_wr - wait_cnt[3:0];
          slot_job[ds] = wait_job[head];
          slot_tag[ds] = wait_tag[head];
          wait_cnt = wait_cnt - 5'd1;
          ev.event_res = EV_REFILLED;
          ev.sent_job = wait_job[head];
        end else begin
          if (pending_cnt[dw] != '0) pending_cnt[dw] = pending_cnt[dw] - 3'd1;
          slot_busy[ds] = 1'b0;
          if (busy_total != '0) busy_total = busy_total - 6'd1;
        end
      end
    end
    ev.busy_count = busy_total;
    ev.waiting_count = wait_cnt;
    return ev;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] dispatcher mismatch: %s", $time, what);
    mismatches_o++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("event %0d %s got %0h expected %0h",
                                evt_seen, name, got, want));
    end
  endtask

  task automatic compare_event(input out_item_t got, input out_item_t want);
    check_field("event_res", 32'(got.event_res), 32'(want.event_res));
    check_field("worker", 32'(got.worker), 32'(want.worker));
    check_field("slot", 32'(got.slot), 32'(want.slot));
    check_field("sent_job", got.sent_job, want.sent_job);
    check_field("finished_tag", got.finished_tag, want.finished_tag);
    check_field("busy_count", 32'(got.busy_count), 32'(want.busy_count));
    check_field("waiting_count", 32'(got.waiting_count), 32'(want.waiting_count));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      workers_cfg = 4'd8;
      limit_cfg = 3'd4;
      for (int w = 0; w < WORKERS; w++) pending_cnt[w] = '0;
      slot_busy = '0;
      slot_owner = '0;
      search_ptr = '0;
      busy_total = '0;
      wait_wr = '0;
      wait_cnt = '0;
      evt_seen = 0;
      event_queue.delete();
      outstanding_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WORKERS_IN_USE: workers_cfg = cfg_wdata_i[3:0];
          CFG_PENDING_LIMIT:  limit_cfg = cfg_wdata_i[2:0];
          default: ;
        endcase
      end
      if (evt_mon.valid && evt_mon.ready) begin
        evt_seen++;
        if (event_queue.size() == 0) begin
          report_mismatch($sformatf("event %0d %h arrived with none outstanding",
                                    evt_seen, evt_mon.data));
        end else begin
          compare_event(evt_mon.data, event_queue.pop_front());
        end
      end
      if (job_mon.valid && job_mon.ready) begin
        event_queue.push_back(dispatch_step(job_mon.data));
      end
      outstanding_o = event_queue.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression of the least-pending job dispatcher
// Drives a short directed sequence and then random push and finish traffic
// across many worker-count and pending-limit settings, with random gaps and
// stalls on both channels; the event checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import jdlp_pkg::*;

  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int LONG_STALL      = 300;
  localparam int DRAIN_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT  = 2000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatches;
  int                    outstanding;
  logic [31:0]           slot_busy;
  logic [31:0][2:0]      slot_owner;
  int                    stall_reqs = 0;
  bit                    rx_calm = 1'b0;
  int                    idle_cycles = 0;

  jdlp_in_if  job_if ();
  jdlp_out_if evt_if ();

  job_dispatcher_least_pending_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .job_i       (job_if),
    .evt_o       (evt_if)
  );

  dispatch_event_check u_event_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .job_mon       (job_if),
    .evt_mon       (evt_if),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .slot_busy_o   (slot_busy),
    .slot_owner_o  (slot_owner)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(2, 1);
    else if (r < 95) return $urandom_range(8, 3);
    else return $urandom_range(60, 20);
  endfunction

  function automatic in_item_t mk_cmd(input action_e act, input logic [31:0] job,
                                      input logic [31:0] tag, input logic [7:0] mask,
                                      input logic [2:0] dw, input logic [4:0] ds);
    in_item_t c;
    c.action = act;
    c.job_handle = job;
    c.completion_tag = tag;
    c.mailbox_free_mask = mask;
    c.done_worker = dw;
    c.done_slot = ds;
    return c;
  endfunction

  function automatic in_item_t make_push();
    int         r;
    logic [7:0] mask;
    r = $urandom_range(99);
    if (r < 55) mask = 8'hFF;
    else if (r < 80) mask = 8'($urandom_range(255));
    else if (r < 92) mask = ~(8'h01 << $urandom_range(7));
    else mask = 8'h01 << $urandom_range(7);
    return mk_cmd(ACT_PUSH, $urandom, $urandom, mask, 3'($urandom_range(7)),
                  5'($urandom_range(31)));
  endfunction

  // aim most finishes at busy slots, usually naming their own worker
  function automatic in_item_t make_finish();
    in_item_t c;
    int       start;
    int       s;
    c = mk_cmd(ACT_FINISH, $urandom, $urandom, 8'($urandom_range(255)),
               3'($urandom_range(7)), 5'($urandom_range(31)));
    if (slot_busy != '0 && $urandom_range(99) < 85) begin
      start = $urandom_range(31);
      for (int k = 0; k < 32; k++) begin
        s = (start + k) % 32;
        if (slot_busy[s]) begin
          c.done_slot = 5'(s);
          if ($urandom_range(99) < 88) c.done_worker = slot_owner[s];
          break;
        end
      end
    end
    return c;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_cmd(input in_item_t c);
    job_if.valid <= 1'b1;
    job_if.data <= c;
    @(posedge clk);
    while (!job_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    job_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_config(input logic [3:0] workers, input logic [3:0] limit);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_WORKERS_IN_USE;
    cfg_wdata <= workers;
    @(negedge clk);
    cfg_idx <= CFG_PENDING_LIMIT;
    cfg_wdata <= limit;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    send_cmd(mk_cmd(ACT_PUSH, 32'h0, 32'h0, 8'hFF, 3'd0, 5'd0));
    send_cmd(mk_cmd(ACT_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 3'd7, 5'd31));
    // no mailbox room anywhere: queue
    send_cmd(mk_cmd(ACT_PUSH, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 8'h00, 3'd0, 5'd0));
    send_cmd(mk_cmd(ACT_PUSH, 32'h1234_5678, 32'h9ABC_DEF0, 8'h80, 3'd5, 5'd10));
    send_cmd(mk_cmd(ACT_PUSH, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 8'h01, 3'd2, 5'd21));
    send_cmd(mk_cmd(ACT_PUSH, 32'h3333_CCCC, 32'hCCCC_3333, 8'h55, 3'd4, 5'd15));
    send_cmd(mk_cmd(ACT_PUSH, 32'h8000_0001, 32'h7FFF_FFFE, 8'hAA, 3'd3, 5'd16));
    // refill from wait head, then finish on an idle slot
    send_cmd(mk_cmd(ACT_FINISH, 32'hDEAD_BEEF, 32'h0BAD_F00D, 8'hFF, 3'd0, 5'd0));
    send_cmd(mk_cmd(ACT_FINISH, 32'h0, 32'h0, 8'h00, 3'd7, 5'd31));
    send_cmd(mk_cmd(ACT_FINISH, 32'h0, 32'h0, 8'h00, 3'd1, 5'd1));
    send_cmd(mk_cmd(ACT_FINISH, 32'h0, 32'h0, 8'h00, 3'd1, 5'd1));
    // wrong worker named: its count must not go below zero
    send_cmd(mk_cmd(ACT_FINISH, 32'h0, 32'h0, 8'h00, 3'd5, 5'd2));
    send_cmd(mk_cmd(ACT_FINISH, 32'h0, 32'h0, 8'h00, 3'd0, 5'd0));
    send_cmd(mk_cmd(ACT_FINISH, 32'h0, 32'h0, 8'h00, 3'd0, 5'd3));
    send_cmd(mk_cmd(ACT_FINISH, 32'h0, 32'h0, 8'h00, 3'd2, 5'd4));
    send_cmd(mk_cmd(ACT_FINISH, 32'h0, 32'h0, 8'h00, 3'd3, 5'd5));
  endtask

  task automatic run_random(input int count, input bit tx_calm);
    int burst;
    int push_pct;
    burst = 0;
    push_pct = 50;
    repeat (count) begin
      if (burst == 0) begin
        burst = $urandom_range(60, 20);
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 50;
          default: push_pct = 25;
        endcase
      end
      burst--;
      if (!tx_calm && $urandom_range(1) == 0) begin
        job_if.valid <= 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end
      send_cmd(($urandom_range(99) < push_pct) ? make_push() : make_finish());
    end
  endtask

  initial begin
    int stall_served;
    stall_served = 0;
    evt_if.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (stall_reqs != stall_served) begin
        stall_served = stall_reqs;
        evt_if.ready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk);
      end
      evt_if.ready <= 1'b1;
      repeat ($urandom_range(16, 1)) @(negedge clk);
      if (!rx_calm) begin
        evt_if.ready <= 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (job_if.valid && job_if.ready) || (evt_if.valid && evt_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("job_dispatcher_least_pending_core regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int workers;
    int limit;
    bit tx_calm;
    job_if.valid = 1'b0;
    job_if.data = '0;
    cfg_we = 1'b0;
    cfg_idx = CFG_WORKERS_IN_USE;
    cfg_wdata = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    drain();
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin workers = 8;  limit = 4; end
        1: begin workers = 1;  limit = 1; end
        2: begin workers = 8;  limit = 1; end
        3: begin workers = 1;  limit = 4; end
        4: begin workers = 0;  limit = 4; end
        5: begin workers = 8;  limit = 0; end
        6: begin workers = 15; limit = 7; end
        7: begin workers = 3;  limit = 2; end
        default: begin
          workers = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(8, 1);
          limit = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(4, 1);
        end
      endcase
      write_config(workers[3:0], limit[3:0]);
      rx_calm = ($urandom_range(3) == 0);
      tx_calm = ($urandom_range(3) == 0);
      if (p == 2 || $urandom_range(3) == 0) stall_reqs++;
      run_random(ITEMS_PER_PHASE, tx_calm);
      drain();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("job_dispatcher_least_pending_core regression: pass");
    end else begin
      $display("job_dispatcher_least_pending_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/jdlp_pkg.sv
rtl/core/jdlp_if.sv
rtl/core/job_dispatcher_least_pending_core.sv
tb/dispatch_event_check.sv
tb/testbench.sv
